// ----- rtl/scy_pkg.sv -----
`default_nettype none
package scy_pkg;

    // Largest message the grid holds
    localparam int unsigned MAX_LEN_DEF = 64;
    // Width of the key register and of every length count (holds 0..127)
    localparam int unsigned KEY_W = 7;
    localparam int unsigned LEN_W = 7;
    localparam logic [KEY_W-1:0] KEY_RESET = 7'd5;

    localparam int unsigned DATA_W = 8;
    localparam int unsigned APB_AW = 3;
    localparam int unsigned APB_DW = 32;

    // Register index as decoded from the APB address
    localparam logic REG_KEY_WIDTH = 1'b0;

    // One finished message, handed from the load side to the emit side
    typedef struct packed {
        logic             bank;
        logic             trunc;
        logic [LEN_W-1:0] len;
    } job_t;

endpackage
`default_nettype wire

// ----- rtl/scy_ram.sv -----
`default_nettype none
module scy_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ----- rtl/scy_front.sv -----
`default_nettype none
module scy_front #(
    parameter int unsigned MAX_LEN = scy_pkg::MAX_LEN_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [scy_pkg::DATA_W-1:0]        s_tdata,
    input  wire logic                              s_tlast,
    input  wire logic                              room,
    output logic                                   ram_we,
    output logic [$clog2(MAX_LEN):0]               ram_waddr,
    output logic [scy_pkg::DATA_W-1:0]             ram_wdata,
    output logic                                   job_push,
    output scy_pkg::job_t                          job
);

    localparam int unsigned AW = $clog2(MAX_LEN);
    localparam logic [scy_pkg::LEN_W-1:0] FULL = scy_pkg::LEN_W'(MAX_LEN);

    logic [scy_pkg::LEN_W-1:0] count_reg, count_next;
    logic                      ovf_reg, ovf_next;
    logic                      bank_reg, bank_next;
    logic                      accept;
    logic                      store;
    logic [scy_pkg::LEN_W-1:0] len_now;

    assign s_tready = room;
    assign accept   = s_tvalid && s_tready;
    assign store    = accept && (count_reg < FULL);
    assign len_now  = store ? count_reg + 1'b1 : count_reg;

    assign ram_we    = store;
    assign ram_waddr = {bank_reg, count_reg[AW-1:0]};
    assign ram_wdata = s_tdata;

    assign job_push  = accept && s_tlast;
    assign job.bank  = bank_reg;
    assign job.trunc = ovf_reg || (accept && !store);
    assign job.len   = len_now;

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        bank_next  = bank_reg;
        if (accept)
        begin
            if (s_tlast)
            begin
                // close the message and move to the other bank
                count_next = '0;
                ovf_next   = 1'b0;
                bank_next  = !bank_reg;
            end
            else
            begin
                count_next = len_now;
                ovf_next   = ovf_reg || !store;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            bank_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            bank_reg  <= bank_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/scy_job_queue.sv -----
`default_nettype none
module scy_job_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  scy_pkg::job_t      push_job,
    input  wire logic          pop,
    output logic               head_valid,
    output scy_pkg::job_t      head,
    output logic [1:0]         count
);

    scy_pkg::job_t slot0_reg, slot1_reg;
    logic [1:0]    count_reg, count_next;
    logic [1:0]    after_pop;

    assign head_valid = (count_reg != 2'd0);
    assign head       = slot0_reg;
    assign count      = count_reg;
    assign after_pop  = count_reg - {1'b0, pop};
    assign count_next = after_pop + {1'b0, push};

    always_ff @(posedge clk)
    begin
        if (push && (after_pop == 2'd0))
        begin
            slot0_reg <= push_job;
        end
        else if (pop)
        begin
            slot0_reg <= slot1_reg;
        end
        if (push && (after_pop != 2'd0))
        begin
            slot1_reg <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/scy_back.sv -----
`default_nettype none
module scy_back #(
    parameter int unsigned MAX_LEN = scy_pkg::MAX_LEN_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [scy_pkg::KEY_W-1:0]    key_width,
    input  wire logic                         job_valid,
    input  scy_pkg::job_t                     job,
    output logic                              job_pop,
    output logic                              busy,
    output logic [$clog2(MAX_LEN):0]          ram_raddr,
    input  wire logic [scy_pkg::DATA_W-1:0]   ram_rdata,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [scy_pkg::DATA_W-1:0]        m_tdata,
    output logic                              m_tlast,
    output logic                              m_tuser
);

    localparam int unsigned AW = $clog2(MAX_LEN);
    localparam int unsigned LW = scy_pkg::LEN_W;
    localparam int unsigned SW = (LW > scy_pkg::KEY_W ? LW : scy_pkg::KEY_W) + 1;

    typedef struct packed {
        logic [scy_pkg::DATA_W-1:0] data;
        logic                       last;
        logic                       trunc;
    } beat_t;

    logic          busy_reg;
    logic          bank_reg;
    logic          trunc_reg;
    logic [LW-1:0] len_reg;
    logic [LW-1:0] col_reg;
    logic [LW-1:0] addr_reg;
    logic [LW-1:0] cnt_reg;
    logic          infl_reg;
    logic          infl_last_reg;
    logic          infl_trunc_reg;
    beat_t         slot0_reg, slot1_reg;
    logic [1:0]    fcount_reg, fcount_next;
    logic [1:0]    after_pop;

    logic [scy_pkg::KEY_W-1:0] key_eff;
    logic [SW-1:0]             step_sum;
    logic [LW-1:0]             cnt_plus;
    logic [LW-1:0]             col_plus;
    logic                      pop;
    logic [2:0]                occupancy;
    logic                      issue;
    logic                      last_issue;
    beat_t                     new_beat;

    // a zero key behaves as a key of one
    assign key_eff   = (key_width == '0) ? scy_pkg::KEY_W'(1) : key_width;
    assign step_sum  = SW'(addr_reg) + SW'(key_eff);
    assign cnt_plus  = cnt_reg + 1'b1;
    assign col_plus  = col_reg + 1'b1;

    assign pop       = m_tvalid && m_tready;
    assign occupancy = 3'(fcount_reg) + 3'(infl_reg) - 3'(pop);
    assign issue     = busy_reg && (occupancy < 3'd2);
    assign last_issue = issue && (cnt_plus == len_reg);

    assign job_pop   = !busy_reg && job_valid;
    assign busy      = busy_reg;
    assign ram_raddr = {bank_reg, addr_reg[AW-1:0]};

    assign new_beat.data  = ram_rdata;
    assign new_beat.last  = infl_last_reg;
    assign new_beat.trunc = infl_trunc_reg;

    assign m_tvalid = (fcount_reg != 2'd0);
    assign m_tdata  = slot0_reg.data;
    assign m_tlast  = slot0_reg.last;
    assign m_tuser  = slot0_reg.trunc;

    assign after_pop   = fcount_reg - {1'b0, pop};
    assign fcount_next = after_pop + {1'b0, infl_reg};

    // job bookkeeping, read-in-flight flag and output beat count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            infl_reg   <= 1'b0;
            fcount_reg <= '0;
        end
        else
        begin
            infl_reg   <= issue;
            fcount_reg <= fcount_next;
            if (job_pop)
            begin
                busy_reg <= 1'b1;
            end
            else if (last_issue)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            bank_reg  <= job.bank;
            trunc_reg <= job.trunc;
            len_reg   <= job.len;
            col_reg   <= '0;
            addr_reg  <= '0;
            cnt_reg   <= '0;
        end
        else if (issue)
        begin
            cnt_reg <= cnt_plus;
            if (step_sum >= SW'(len_reg))
            begin
                // column done: start the next one at the top row
                col_reg  <= col_plus;
                addr_reg <= col_plus;
            end
            else
            begin
                addr_reg <= step_sum[LW-1:0];
            end
        end
        if (issue)
        begin
            infl_last_reg  <= last_issue;
            infl_trunc_reg <= trunc_reg;
        end
        if (infl_reg && (after_pop == 2'd0))
        begin
            slot0_reg <= new_beat;
        end
        else if (pop)
        begin
            slot0_reg <= slot1_reg;
        end
        if (infl_reg && (after_pop != 2'd0))
        begin
            slot1_reg <= new_beat;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/scytale_transposition.sv -----
`default_nettype none
// Channel  | Signals                                   | Beat
// ---------+-------------------------------------------+----------------------------------
// s_*      | s_tvalid s_tready s_tdata s_tlast         | one message byte, tlast = final
// m_*      | m_tvalid m_tready m_tdata m_tlast m_tuser | one transposed byte, tuser = trunc
// APB      | psel penable pwrite paddr pwdata prdata   | key_width at address 0
//
// Input takes one byte per cycle while it has room. When the final byte lands,
// the message is queued and its L bytes leave one per cycle while m_tready is
// high; the single RAM read port sets that output rate.
// Two RAM banks let the next message load while the previous one drains; the
// input stalls only when both banks hold unsent messages.
// Reset (rst_n, asynchronous) clears counts, queue and output beats; the RAM
// needs no clearing. A stall on m_tready holds the output without loss.
module scytale_transposition #(
    parameter int unsigned MAX_LEN = scy_pkg::MAX_LEN_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // slave stream
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [7:0]                   s_tdata,   // [7:0] char_in
    input  wire logic                         s_tlast,   // last_in
    // master stream
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [7:0]                        m_tdata,   // [7:0] char_out
    output logic                              m_tlast,   // last_out
    output logic                              m_tuser,   // [0] truncated
    // configuration
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [scy_pkg::APB_AW-1:0]   paddr,
    input  wire logic [scy_pkg::APB_DW-1:0]   pwdata,
    output logic      [scy_pkg::APB_DW-1:0]   prdata,
    output logic                              pready
);

    localparam int unsigned RAW = $clog2(MAX_LEN) + 1;

    logic [scy_pkg::KEY_W-1:0] key_reg;
    logic                      reg_sel;

    logic                      room;
    logic                      ram_we;
    logic [RAW-1:0]            ram_waddr;
    logic [scy_pkg::DATA_W-1:0] ram_wdata;
    logic [RAW-1:0]            ram_raddr;
    logic [scy_pkg::DATA_W-1:0] ram_rdata;

    logic                      job_push;
    scy_pkg::job_t             job_in;
    logic                      job_pop;
    logic                      job_valid;
    scy_pkg::job_t             job_head;
    logic [1:0]                job_count;
    logic                      back_busy;

    // APB: single register, zero wait states
    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == scy_pkg::REG_KEY_WIDTH);
    assign prdata  = reg_sel ? scy_pkg::APB_DW'(key_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= scy_pkg::KEY_RESET;
        end
        else if (psel && penable && pwrite && pready && reg_sel)
        begin
            key_reg <= pwdata[scy_pkg::KEY_W-1:0];
        end
    end

    // a bank is free while fewer than two messages wait or drain
    assign room = (3'(job_count) + 3'(back_busy)) < 3'd2;

    scy_front #(
        .MAX_LEN (MAX_LEN)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .room      (room),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .job_push  (job_push),
        .job       (job_in)
    );

    // each bank spans a full power-of-two window so the bank bit never
    // lands past the end of the array
    scy_ram #(
        .WIDTH (scy_pkg::DATA_W),
        .DEPTH (2 ** RAW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    scy_job_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (job_push),
        .push_job   (job_in),
        .pop        (job_pop),
        .head_valid (job_valid),
        .head       (job_head),
        .count      (job_count)
    );

    scy_back #(
        .MAX_LEN (MAX_LEN)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_width (key_reg),
        .job_valid (job_valid),
        .job       (job_head),
        .job_pop   (job_pop),
        .busy      (back_busy),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule
`default_nettype wire
